>>> rtl/mme_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_pkg: shared types and constants of the matrix multiply engine
// Item layouts, command codes, configuration register indexes and the
// arithmetic helpers used by the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM     = 8;
  localparam int ELEM_BITS   = 16;
  localparam int IDX_W       = 3;               // row and column index width
  localparam int DIM_W       = 4;               // configuration register width
  localparam int ADDR_W      = 2 * IDX_W;       // element store address
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int PROD_W      = 2 * ELEM_BITS;
  localparam int ACC_W       = PROD_W + IDX_W + 1;
  localparam int RES_W       = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int CQ_DEPTH    = 4;
  localparam int CQ_PTR_W    = 2;
  localparam int OQ_DEPTH    = 2;
  localparam int OQ_PTR_W    = 1;

  typedef enum logic [1:0] {
    KIND_LOAD_A = 2'd0,
    KIND_LOAD_B = 2'd1,
    KIND_START  = 2'd2
  } in_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_COUNT  = 2'd0,
    CFG_INNER_SIZE = 2'd1,
    CFG_COL_COUNT  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_START
  } cmd_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_MAC,
    BK_DRAIN
  } back_state_t;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [IDX_W-1:0]            row_index;
    logic [IDX_W-1:0]            col_index;
    logic signed [ELEM_BITS-1:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [RES_W-1:0] product_value;
    logic                    last_element;
  } out_item_t;

  typedef struct packed {
    cmd_op_t                     op;
    logic [IDX_W-1:0]            row;
    logic [IDX_W-1:0]            col;
    logic signed [ELEM_BITS-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cols;
  } dims_t;

  // A zero dimension counts as one, anything above the store size as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Saturate the exact sum to the signed Q16.16 result range.
  function automatic logic signed [RES_W-1:0] sat_result(input logic signed [ACC_W-1:0] v);
    logic              fits;
    logic [RES_W-1:0]  r;
    fits = (&v[ACC_W-1:RES_W-1]) | ~(|v[ACC_W-1:RES_W-1]);
    if (fits) begin
      r = v[RES_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(RES_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/mme_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_front: input acceptance and classification
// Turns accepted items into commands and drops items that do nothing.
// ----------------------------------------------------------------------------
module mme_front (
  input  wire  logic              in_push,
  output       logic              in_full,
  input  wire  mme_pkg::in_item_t in_item,
  input  wire  logic              q_full,
  output       logic              q_push,
  output       mme_pkg::cmd_t     q_cmd
);

  logic keep;
  logic idx_ok;

  // Stores are indexed by row and column, so both must fall inside the store.
  assign idx_ok = ({1'b0, in_item.row_index} < (mme_pkg::IDX_W + 1)'(mme_pkg::MAX_DIM)) &&
                  ({1'b0, in_item.col_index} < (mme_pkg::IDX_W + 1)'(mme_pkg::MAX_DIM));

  always_comb begin
    q_cmd.row   = in_item.row_index;
    q_cmd.col   = in_item.col_index;
    q_cmd.value = in_item.element_value;
    case (in_item.kind)
      mme_pkg::KIND_LOAD_A: begin
        q_cmd.op = mme_pkg::OP_LOAD_A;
        keep     = idx_ok;
      end
      mme_pkg::KIND_LOAD_B: begin
        q_cmd.op = mme_pkg::OP_LOAD_B;
        keep     = idx_ok;
      end
      mme_pkg::KIND_START: begin
        q_cmd.op = mme_pkg::OP_START;
        keep     = 1'b1;
      end
      default: begin
        q_cmd.op = mme_pkg::OP_START;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_full = q_full;
  assign q_push  = in_push & ~q_full & keep;

endmodule
`default_nettype wire

>>> rtl/mme_cmd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_cmd_queue: command queue between front end and back end
// A small first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module mme_cmd_queue (
  input  wire  logic          clk,
  input  wire  logic          rst_n,
  input  wire  logic          push,
  input  wire  mme_pkg::cmd_t push_cmd,
  output       logic          full,
  output       logic          empty,
  output       mme_pkg::cmd_t head,
  input  wire  logic          pop
);

  mme_pkg::cmd_t               slot_r [mme_pkg::CQ_DEPTH];
  logic [mme_pkg::CQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [mme_pkg::CQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [mme_pkg::CQ_PTR_W:0]   cnt_r, cnt_nxt;
  logic                         do_push, do_pop;

  assign full    = (cnt_r == (mme_pkg::CQ_PTR_W + 1)'(mme_pkg::CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign head    = slot_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

>>> rtl/mme_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_back: element stores, multiply-accumulate sequencer and result queue
// Executes load commands into the A and B stores and runs start commands
// through one shared multiply-accumulate pipeline, one product element at a time.
// ----------------------------------------------------------------------------
module mme_back (
  input  wire  logic               clk,
  input  wire  logic               rst_n,
  input  wire  mme_pkg::dims_t     dims,
  input  wire  logic               cmd_empty,
  input  wire  mme_pkg::cmd_t      cmd,
  output       logic               cmd_pop,
  output       logic               out_empty,
  input  wire  logic               out_pop,
  output       mme_pkg::out_item_t out_item
);

  localparam int IW = mme_pkg::IDX_W;
  localparam int DW = mme_pkg::DIM_W;

  mme_pkg::back_state_t state_r, state_nxt;
  mme_pkg::dims_t       dims_r, dims_nxt;
  logic [IW-1:0]        i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;

  logic signed [mme_pkg::ELEM_BITS-1:0] mem_a [mme_pkg::STORE_DEPTH];
  logic signed [mme_pkg::ELEM_BITS-1:0] mem_b [mme_pkg::STORE_DEPTH];
  logic signed [mme_pkg::ELEM_BITS-1:0] a_rd_r, b_rd_r;
  logic signed [mme_pkg::PROD_W-1:0]    prod_r;
  logic signed [mme_pkg::ACC_W-1:0]     acc_r, acc_nxt;

  logic wr_a, wr_b, issue, issue_first, issue_last;
  logic s1_valid_r, s1_first_r, s1_last_r;
  logic s2_valid_r, s2_first_r, s2_last_r;
  logic done_r, elem_last;

  mme_pkg::out_item_t             oq_r [mme_pkg::OQ_DEPTH];
  logic [mme_pkg::OQ_PTR_W-1:0]   oq_wr_r, oq_rd_r;
  logic [mme_pkg::OQ_PTR_W:0]     oq_cnt_r;
  logic                           oq_full, oq_push, oq_pop;
  mme_pkg::out_item_t             oq_item;

  assign oq_full     = (oq_cnt_r == (mme_pkg::OQ_PTR_W + 1)'(mme_pkg::OQ_DEPTH));
  assign out_empty   = (oq_cnt_r == '0);
  assign out_item    = oq_r[oq_rd_r];
  assign oq_pop      = out_pop & ~out_empty;
  assign issue_first = (k_r == '0);
  assign issue_last  = ({1'b0, k_r} == dims_r.inner - DW'(1));
  assign elem_last   = ({1'b0, i_r} == dims_r.rows - DW'(1)) &&
                       ({1'b0, j_r} == dims_r.cols - DW'(1));

  // Sequencer: a load writes its store straight from idle, a start walks i, j and k.
  always_comb begin
    state_nxt = state_r;
    dims_nxt  = dims_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd_pop   = 1'b0;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    issue     = 1'b0;
    oq_push   = 1'b0;
    case (state_r)
      mme_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            mme_pkg::OP_LOAD_A: wr_a = 1'b1;
            mme_pkg::OP_LOAD_B: wr_b = 1'b1;
            mme_pkg::OP_START: begin
              dims_nxt.rows  = mme_pkg::clamp_dim(dims.rows);
              dims_nxt.inner = mme_pkg::clamp_dim(dims.inner);
              dims_nxt.cols  = mme_pkg::clamp_dim(dims.cols);
              i_nxt          = '0;
              j_nxt          = '0;
              k_nxt          = '0;
              state_nxt      = mme_pkg::BK_MAC;
            end
            default: ;
          endcase
        end
      end
      mme_pkg::BK_MAC: begin
        // An element starts only when its result has a place to go.
        issue = ~issue_first | ~oq_full;
        if (issue) begin
          if (issue_last) begin
            k_nxt     = '0;
            state_nxt = mme_pkg::BK_DRAIN;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      mme_pkg::BK_DRAIN: begin
        if (done_r) begin
          oq_push = 1'b1;
          if (elem_last) begin
            state_nxt = mme_pkg::BK_IDLE;
          end else begin
            state_nxt = mme_pkg::BK_MAC;
            if ({1'b0, j_r} == dims_r.cols - DW'(1)) begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = mme_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mme_pkg::BK_IDLE;
      dims_r     <= '0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      s1_valid_r <= 1'b0;
      s1_first_r <= 1'b0;
      s1_last_r  <= 1'b0;
      s2_valid_r <= 1'b0;
      s2_first_r <= 1'b0;
      s2_last_r  <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      dims_r     <= dims_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
      s1_valid_r <= issue;
      s1_first_r <= issue_first;
      s1_last_r  <= issue_last;
      s2_valid_r <= s1_valid_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      done_r     <= s2_valid_r & s2_last_r;
    end
  end

  // Element stores: one write port from loads, one registered read port each.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[{cmd.row, cmd.col}] <= cmd.value;
    end
    if (wr_b) begin
      mem_b[{cmd.row, cmd.col}] <= cmd.value;
    end
    a_rd_r <= mem_a[{i_r, k_r}];
    b_rd_r <= mem_b[{k_r, j_r}];
  end

  always_comb begin
    acc_nxt = (s2_first_r ? '0 : acc_r) + mme_pkg::ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    prod_r <= a_rd_r * b_rd_r;
    if (s2_valid_r) begin
      acc_r <= acc_nxt;
    end
  end

  // Result queue.
  always_comb begin
    oq_item.out_row       = i_r;
    oq_item.out_col       = j_r;
    oq_item.product_value = mme_pkg::sat_result(acc_r);
    oq_item.last_element  = elem_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_r <= oq_wr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_r <= oq_rd_r + 1'b1;
      end
      if (oq_push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !oq_push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wr_r] <= oq_item;
    end
  end

endmodule
`default_nettype wire

>>> rtl/matrix_multiply_engine.sv
// Flow: a load item enters the command queue on acceptance and is written into its store
// when the idle back end pops it. For each element of a start the back end issues one store
// read per inner index into the shared multiply-accumulate pipeline (store read, product and
// accumulator registers), lets it drain and pushes the element into the result queue.
// Throughput: one load item per cycle while the back end is free. Reset (rst_n, synchronous,
// active low) empties both queues, idles the sequencer and sets the dimensions to 8.
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_engine: fixed-point matrix multiply, top level
// Loads A and B one element at a time and streams out the product A*B in
// row-major order as saturated signed Q16.16 values.
// ----------------------------------------------------------------------------
module matrix_multiply_engine (
  input  wire  logic                              clk,
  input  wire  logic                              rst_n,
  // Input items: load A element, load B element or start.
  input  wire  logic                              in_push,
  output       logic                              in_full,
  input  wire  mme_pkg::in_item_t                 in_item,
  // Product elements.
  output       logic                              out_empty,
  input  wire  logic                              out_pop,
  output       mme_pkg::out_item_t                out_item,
  // Dimension registers.
  input  wire  logic                              cfg_valid,
  output       logic                              cfg_ready,
  input  wire  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  logic [mme_pkg::DIM_W-1:0]         cfg_data
);

  // Raw dimension registers. They are clamped into range when a start item is
  // picked up by the back end, so a write of zero or of a too-large value is
  // harmless here. The element stores are undefined until written.
  mme_pkg::dims_t dims_r, dims_nxt;

  // Front end to command queue.
  logic          q_push;
  logic          q_full;
  mme_pkg::cmd_t q_cmd;

  // Command queue to back end.
  logic          cq_empty;
  logic          cq_pop;
  mme_pkg::cmd_t cq_head;

  // Configuration is never back-pressured.
  assign cfg_ready = 1'b1;

  always_comb begin
    dims_nxt = dims_r;
    if (cfg_valid) begin
      case (cfg_index)
        mme_pkg::CFG_ROW_COUNT:  dims_nxt.rows  = cfg_data;
        mme_pkg::CFG_INNER_SIZE: dims_nxt.inner = cfg_data;
        mme_pkg::CFG_COL_COUNT:  dims_nxt.cols  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.rows  <= mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
      dims_r.inner <= mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
      dims_r.cols  <= mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
    end else begin
      dims_r <= dims_nxt;
    end
  end

  // The front end classifies each accepted item and drops those that have no
  // effect (the unused kind and loads outside the store).
  mme_front u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  // The command queue lets loads stream in while the back end is busy with a
  // multiply; commands are executed strictly in arrival order, so a load that
  // follows a start never disturbs that start's operands.
  mme_cmd_queue u_cq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .empty    (cq_empty),
    .head     (cq_head),
    .pop      (cq_pop)
  );

  // The back end owns the element stores, the multiply-accumulate pipeline
  // and the result queue that faces the output port.
  mme_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims_r),
    .cmd_empty (cq_empty),
    .cmd       (cq_head),
    .cmd_pop   (cq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

>>> rtl/mme_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mme_checker: port-level checks for the matrix multiply engine
// Tracks the dimension registers from the configuration port and checks the
// product stream against them.
// ----------------------------------------------------------------------------
module mme_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_full,
  input wire logic                          out_empty,
  input wire logic                          out_pop,
  input wire mme_pkg::out_item_t            out_item,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready,
  input wire logic [mme_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [mme_pkg::DIM_W-1:0]     cfg_data
);

  logic [mme_pkg::DIM_W-1:0] rows_r, cols_r;
  logic [mme_pkg::DIM_W-1:0] rows_c, cols_c;

  assign rows_c = mme_pkg::clamp_dim(rows_r);
  assign cols_c = mme_pkg::clamp_dim(cols_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
      cols_r <= mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mme_pkg::CFG_ROW_COUNT) begin
        rows_r <= cfg_data;
      end
      if (cfg_index == mme_pkg::CFG_COL_COUNT) begin
        cols_r <= cfg_data;
      end
    end
  end

  // No result survives reset, and the input side is open right after it.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("result shown or input blocked right after reset");

  // A waiting result that is not taken stays as it is.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result changed or vanished");

  // Every element lies inside the product's configured shape.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> ({1'b0, out_item.out_row} < rows_c) &&
                   ({1'b0, out_item.out_col} < cols_c))
    else $error("product element outside the configured shape");

  // The last element sits in the bottom-right corner.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.last_element |->
      ({1'b0, out_item.out_row} == rows_c - 1'b1) &&
      ({1'b0, out_item.out_col} == cols_c - 1'b1))
    else $error("last element flag away from the final element");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);
`default_nettype wire

>>> sim/tb_matrix_multiply_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix_multiply_engine: self-checking testbench of the matrix multiply engine
// Loads element stores, starts multiplies under many dimension settings and
// checks every product element against an in-bench model of the arithmetic.
// ----------------------------------------------------------------------------
module tb_matrix_multiply_engine;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 9;
  // A load queued behind the last multiply still lands after the final product
  // element, so the bench waits this long before touching the dimension
  // registers.
  localparam int DRAIN_CYCLES = 32;
  localparam int IDLE_PERCENT = 32;
  localparam int RANDOM_ITEMS = 230;
  localparam int TIMEOUT_NS   = 20_000_000;

  // Codes outside the package enums, used to check that they are ignored.
  localparam logic [1:0]                    KIND_UNUSED = 2'd3;
  localparam logic [mme_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;

  localparam logic signed [mme_pkg::ELEM_BITS-1:0] ELEM_MIN =
    {1'b1, {(mme_pkg::ELEM_BITS-1){1'b0}}};
  localparam logic signed [mme_pkg::ELEM_BITS-1:0] ELEM_MAX =
    {1'b0, {(mme_pkg::ELEM_BITS-1){1'b1}}};
  localparam logic signed [mme_pkg::ELEM_BITS-1:0] ELEM_ONE =
    mme_pkg::ELEM_BITS'(256);  // 1.0 in Q8.8
  localparam logic signed [mme_pkg::RES_W-1:0] RES_MIN = {1'b1, {(mme_pkg::RES_W-1){1'b0}}};
  localparam logic signed [mme_pkg::RES_W-1:0] RES_MAX = {1'b0, {(mme_pkg::RES_W-1){1'b1}}};
  localparam longint                           SUM_MIN = -64'sd2147483648;
  localparam longint                           SUM_MAX = 64'sd2147483647;

  logic                          clk;
  logic                          rst_n;
  logic                          in_push;
  logic                          in_full;
  mme_pkg::in_item_t             in_item;
  logic                          out_empty;
  logic                          out_pop;
  mme_pkg::out_item_t            out_item;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [mme_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [mme_pkg::DIM_W-1:0]     cfg_data;

  matrix_multiply_engine uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of the engine state. The loaded flags keep every multiply away
  // from store entries that were never written, since those hold garbage.
  logic signed [mme_pkg::ELEM_BITS-1:0] a_mirror [mme_pkg::STORE_DEPTH];
  logic signed [mme_pkg::ELEM_BITS-1:0] b_mirror [mme_pkg::STORE_DEPTH];
  bit                                   a_loaded [mme_pkg::STORE_DEPTH];
  bit                                   b_loaded [mme_pkg::STORE_DEPTH];
  logic [mme_pkg::DIM_W-1:0]            rows_setting;
  logic [mme_pkg::DIM_W-1:0]            inner_setting;
  logic [mme_pkg::DIM_W-1:0]            cols_setting;

  // Product elements still owed by the engine, oldest first.
  mme_pkg::out_item_t expected_products [$];
  mme_pkg::out_item_t product_due;

  int error_count;
  int items_sent;
  int starts_sent;
  int products_checked;
  // While set, neither side inserts idle cycles.
  bit steady_flow;

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // A register value of zero behaves as one, anything past the store size as
  // the store size.
  function automatic int effective_dim(input logic [mme_pkg::DIM_W-1:0] raw);
    if (raw == '0) begin
      return 1;
    end
    if (raw > mme_pkg::DIM_W'(mme_pkg::MAX_DIM)) begin
      return mme_pkg::MAX_DIM;
    end
    return int'(raw);
  endfunction

  function automatic logic [mme_pkg::DIM_W-1:0] pick_dim();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) begin
      return '0;
    end
    if (roll < 16) begin
      return mme_pkg::DIM_W'($urandom_range(15, mme_pkg::MAX_DIM + 1));
    end
    if (roll < 26) begin
      return mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
    end
    // Small products keep most multiplies short.
    return mme_pkg::DIM_W'($urandom_range(4, 1));
  endfunction

  function automatic logic signed [mme_pkg::ELEM_BITS-1:0] random_element();
    if ($urandom_range(99) < 20) begin
      case ($urandom_range(3))
        0:       return ELEM_MIN;
        1:       return ELEM_MAX;
        2:       return '0;
        default: return '1;
      endcase
    end
    return mme_pkg::ELEM_BITS'($urandom);
  endfunction

  // Every product element is an exact sum of Q8.8 by Q8.8 products, held in
  // 64 bits and then clamped to the signed Q16.16 range.
  task automatic predict_product_elements();
    int                 rows;
    int                 inner;
    int                 cols;
    longint             sum;
    mme_pkg::out_item_t elem;
    rows  = effective_dim(rows_setting);
    inner = effective_dim(inner_setting);
    cols  = effective_dim(cols_setting);
    for (int i = 0; i < rows; i++) begin
      for (int j = 0; j < cols; j++) begin
        sum = 0;
        for (int k = 0; k < inner; k++) begin
          sum += longint'(a_mirror[i * mme_pkg::MAX_DIM + k]) *
                 longint'(b_mirror[k * mme_pkg::MAX_DIM + j]);
        end
        elem.out_row       = mme_pkg::IDX_W'(i);
        elem.out_col       = mme_pkg::IDX_W'(j);
        elem.product_value = (sum > SUM_MAX) ? RES_MAX :
                             (sum < SUM_MIN) ? RES_MIN : sum[mme_pkg::RES_W-1:0];
        elem.last_element  = (i == rows - 1) && (j == cols - 1);
        expected_products.insert(expected_products.size(), elem);
      end
    end
  endtask

  // Applies one accepted item to the bench state. Unused kinds change nothing.
  task automatic apply_item(input mme_pkg::in_item_t it);
    case (it.kind)
      mme_pkg::KIND_LOAD_A: begin
        a_mirror[{it.row_index, it.col_index}] = it.element_value;
        a_loaded[{it.row_index, it.col_index}] = 1'b1;
      end
      mme_pkg::KIND_LOAD_B: begin
        b_mirror[{it.row_index, it.col_index}] = it.element_value;
        b_loaded[{it.row_index, it.col_index}] = 1'b1;
      end
      mme_pkg::KIND_START: begin
        predict_product_elements();
        starts_sent++;
      end
      default: begin
      end
    endcase
  endtask

  // Offers one item, entered and left at a falling edge. Push stays high on
  // return so that back-to-back items see no bubble.
  task automatic send_item(input mme_pkg::in_item_t it);
    while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) begin
      @(posedge clk);
    end
    apply_item(it);
    if (it.kind != KIND_UNUSED) begin
      items_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_load(input logic [1:0] kind, input int row, input int col,
                           input logic signed [mme_pkg::ELEM_BITS-1:0] value);
    mme_pkg::in_item_t it;
    it.kind          = kind;
    it.row_index     = mme_pkg::IDX_W'(row);
    it.col_index     = mme_pkg::IDX_W'(col);
    it.element_value = value;
    send_item(it);
  endtask

  // Before a start, any operand the multiply will read that was never loaded
  // gets a random value, so no product ever depends on garbage.
  task automatic send_start();
    int                rows;
    int                inner;
    int                cols;
    mme_pkg::in_item_t it;
    rows  = effective_dim(rows_setting);
    inner = effective_dim(inner_setting);
    cols  = effective_dim(cols_setting);
    for (int i = 0; i < rows; i++) begin
      for (int k = 0; k < inner; k++) begin
        if (!a_loaded[i * mme_pkg::MAX_DIM + k]) begin
          send_load(mme_pkg::KIND_LOAD_A, i, k, random_element());
        end
      end
    end
    for (int k = 0; k < inner; k++) begin
      for (int j = 0; j < cols; j++) begin
        if (!b_loaded[k * mme_pkg::MAX_DIM + j]) begin
          send_load(mme_pkg::KIND_LOAD_B, k, j, random_element());
        end
      end
    end
    // The other fields of a start carry no meaning; they are randomized.
    it.kind          = mme_pkg::KIND_START;
    it.row_index     = mme_pkg::IDX_W'($urandom);
    it.col_index     = mme_pkg::IDX_W'($urandom);
    it.element_value = random_element();
    send_item(it);
  endtask

  task automatic send_noise();
    mme_pkg::in_item_t it;
    it.kind          = KIND_UNUSED;
    it.row_index     = mme_pkg::IDX_W'($urandom);
    it.col_index     = mme_pkg::IDX_W'($urandom);
    it.element_value = random_element();
    send_item(it);
  endtask

  // Valid is left high on return; the caller lowers it after its last write.
  task automatic write_register(input logic [mme_pkg::CFG_IDX_W-1:0] index,
                                input logic [mme_pkg::DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (index)
      mme_pkg::CFG_ROW_COUNT:  rows_setting  = data;
      mme_pkg::CFG_INNER_SIZE: inner_setting = data;
      mme_pkg::CFG_COL_COUNT:  cols_setting  = data;
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic program_dims(input logic [mme_pkg::DIM_W-1:0] rows,
                              input logic [mme_pkg::DIM_W-1:0] inner,
                              input logic [mme_pkg::DIM_W-1:0] cols);
    write_register(mme_pkg::CFG_ROW_COUNT, rows);
    write_register(mme_pkg::CFG_INNER_SIZE, inner);
    write_register(mme_pkg::CFG_COL_COUNT, cols);
    cfg_valid <= 1'b0;
  endtask

  // Returns once every owed product element has arrived and any trailing load
  // has had time to settle.
  task automatic wait_for_idle();
    in_push <= 1'b0;
    while (expected_products.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Zero in every register collapses the product to one element. The most
  // negative element squared gives exactly 2^30. An unused kind and a write to
  // the unused register index must both leave the engine untouched.
  task automatic test_zero_dims();
    program_dims('0, '0, '0);
    send_load(mme_pkg::KIND_LOAD_A, 0, 0, ELEM_MIN);
    send_load(mme_pkg::KIND_LOAD_B, 0, 0, ELEM_MIN);
    send_noise();
    send_start();
    wait_for_idle();
    write_register(CFG_UNUSED, '1);
    cfg_valid <= 1'b0;
    send_start();
  endtask

  // With three terms of 2^30 the first column overflows upward and the second,
  // built from the most negative times the most positive, overflows downward.
  // Two terms of 2^30 land exactly one past the positive limit.
  task automatic test_saturation();
    wait_for_idle();
    program_dims(mme_pkg::DIM_W'(1), mme_pkg::DIM_W'(3), mme_pkg::DIM_W'(2));
    for (int k = 1; k < 3; k++) begin
      send_load(mme_pkg::KIND_LOAD_A, 0, k, ELEM_MIN);
      send_load(mme_pkg::KIND_LOAD_B, k, 0, ELEM_MIN);
    end
    for (int k = 0; k < 3; k++) begin
      send_load(mme_pkg::KIND_LOAD_B, k, 1, ELEM_MAX);
    end
    send_start();
    wait_for_idle();
    program_dims(mme_pkg::DIM_W'(1), mme_pkg::DIM_W'(2), mme_pkg::DIM_W'(1));
    send_start();
  endtask

  // A load that follows a start must not change the products of that start,
  // only those of the next one.
  task automatic test_load_behind_start();
    wait_for_idle();
    program_dims(mme_pkg::DIM_W'(2), mme_pkg::DIM_W'(2), mme_pkg::DIM_W'(2));
    steady_flow = 1'b1;
    send_start();
    send_load(mme_pkg::KIND_LOAD_A, 0, 0, ELEM_ONE);
    send_load(mme_pkg::KIND_LOAD_B, 1, 1, '1);
    send_start();
    steady_flow = 1'b0;
  endtask

  // Phases of random loads and starts, each under new dimension settings. The
  // first two phases use the full store, directly and through an oversized
  // register value; the fourth runs with no idle cycles on either side.
  task automatic test_random_traffic();
    int         phase;
    int         base;
    int         roll;
    logic [1:0] kind;
    int         row_limit;
    int         col_limit;
    phase = 0;
    base  = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      wait_for_idle();
      steady_flow = (phase == 3);
      if (phase == 0) begin
        program_dims(mme_pkg::DIM_W'(mme_pkg::MAX_DIM), mme_pkg::DIM_W'(mme_pkg::MAX_DIM),
                     mme_pkg::DIM_W'(mme_pkg::MAX_DIM));
      end else if (phase == 1) begin
        program_dims('1, '1, '1);
      end else begin
        program_dims(pick_dim(), pick_dim(), pick_dim());
      end
      repeat ($urandom_range(20, 6)) begin
        roll = $urandom_range(99);
        if (roll < 70) begin
          kind = $urandom_range(1) ? mme_pkg::KIND_LOAD_B : mme_pkg::KIND_LOAD_A;
          // Most loads hit the part of the store that the next start reads.
          if ($urandom_range(3) != 0) begin
            row_limit = (kind == mme_pkg::KIND_LOAD_A) ? effective_dim(rows_setting)
                                                       : effective_dim(inner_setting);
            col_limit = (kind == mme_pkg::KIND_LOAD_A) ? effective_dim(inner_setting)
                                                       : effective_dim(cols_setting);
          end else begin
            row_limit = mme_pkg::MAX_DIM;
            col_limit = mme_pkg::MAX_DIM;
          end
          send_load(kind, $urandom_range(row_limit - 1), $urandom_range(col_limit - 1),
                    random_element());
        end else if (roll < 85) begin
          send_start();
        end else begin
          send_noise();
        end
      end
      send_start();
      phase++;
    end
    steady_flow = 1'b0;
  endtask

  // The result side pops at random, except during the steady stretch.
  always @(negedge clk) begin
    out_pop <= rst_n && (steady_flow || $urandom_range(99) >= IDLE_PERCENT);
  end

  // Each popped product element is compared with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_products.size() == 0) begin
        $error("product element row %0d col %0d arrived with none owed",
               out_item.out_row, out_item.out_col);
        error_count++;
      end else begin
        product_due = expected_products.pop_front();
        if (out_item.out_row !== product_due.out_row) begin
          $error("out_row mismatch: expected %0d, actual %0d",
                 product_due.out_row, out_item.out_row);
          error_count++;
        end
        if (out_item.out_col !== product_due.out_col) begin
          $error("out_col mismatch: expected %0d, actual %0d",
                 product_due.out_col, out_item.out_col);
          error_count++;
        end
        if (out_item.product_value !== product_due.product_value) begin
          $error("product_value mismatch at (%0d,%0d): expected %0d, actual %0d",
                 product_due.out_row, product_due.out_col,
                 product_due.product_value, out_item.product_value);
          error_count++;
        end
        if (out_item.last_element !== product_due.last_element) begin
          $error("last_element mismatch at (%0d,%0d): expected %0d, actual %0d",
                 product_due.out_row, product_due.out_col,
                 product_due.last_element, out_item.last_element);
          error_count++;
        end
        products_checked++;
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb_matrix_multiply_engine failed");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_item          = '0;
    out_pop          = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    steady_flow      = 1'b0;
    error_count      = 0;
    items_sent       = 0;
    starts_sent      = 0;
    products_checked = 0;
    rows_setting     = mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
    inner_setting    = mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
    cols_setting     = mme_pkg::DIM_W'(mme_pkg::MAX_DIM);
    for (int n = 0; n < mme_pkg::STORE_DEPTH; n++) begin
      a_mirror[n] = '0;
      b_mirror[n] = '0;
      a_loaded[n] = 1'b0;
      b_loaded[n] = 1'b0;
    end
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_zero_dims();
    test_saturation();
    test_load_behind_start();
    test_random_traffic();
    wait_for_idle();

    $display("Sent %0d load and start items, %0d of them starts; checked %0d product elements.",
             items_sent, starts_sent, products_checked);
    $display("Dimensions ranged from zero to oversized register values, with saturation both ways.");
    if (error_count == 0) begin
      $display("tb_matrix_multiply_engine passed");
    end else begin
      $display("tb_matrix_multiply_engine failed");
    end
    $finish;
  end

endmodule
